// ===== rtl/core/pse_pkg.sv =====
// Shared types, constants and the CRC byte update for the PNG stored-deflate encoder.
`default_nettype none
package pse_pkg;

  // Head of the input queue as seen by the back end
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } head_t;

  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
  localparam logic [31:0] IEND_CRC  = 32'hAE426082;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Reflected CRC-32 over one byte, bitwise
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pse_in_queue.sv =====
// Front end: two-entry queue that takes colour bytes and presents the head word.
`default_nettype none
module pse_in_queue
  import pse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] pixel_byte,
  input  wire logic       pop,
  output head_t           head
);

  logic [7:0] slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != 2'd0);
  assign head.data  = slots[rd_ptr];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= pixel_byte;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pse_seq.sv =====
// Back end: byte sequencer that builds the PNG stream, checksums and block framing.
`default_nettype none
module pse_seq
  import pse_pkg::*;
#(
  parameter int BLOCK_LIMIT = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [13:0] image_width,
  input  wire logic [13:0] image_height,
  input  wire head_t       head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_file
);

  localparam logic [2:0] P_START = 3'd0;
  localparam logic [2:0] P_HDR   = 3'd1;
  localparam logic [2:0] P_FBH   = 3'd2;
  localparam logic [2:0] P_FB    = 3'd3;
  localparam logic [2:0] P_PBH   = 3'd4;
  localparam logic [2:0] P_PB    = 3'd5;
  localparam logic [2:0] P_TRL   = 3'd6;

  localparam logic [15:0] LIMIT16 = 16'(BLOCK_LIMIT);
  localparam logic [29:0] LIMIT30 = 30'(BLOCK_LIMIT);
  localparam logic [5:0]  RUN_CAP = 6'd50;

  // Reciprocal of the block size, exact for numerators below 2^30
  localparam int          DIV_SHIFT = 30 + $clog2(BLOCK_LIMIT);
  localparam logic [30:0] BLK_RECIP =
    31'(((64'd1 << DIV_SHIFT) + 64'(BLOCK_LIMIT) - 64'd1) / 64'(BLOCK_LIMIT));

  logic [2:0]  ph;
  logic [5:0]  idx;
  logic [5:0]  cnt;
  logic        started;
  logic [31:0] crc;
  logic [31:0] ihdr_crc;
  logic [15:0] adl_lo;
  logic [15:0] adl_hi;
  logic [15:0] col;
  logic [15:0] blk;
  logic [29:0] raw_left;
  logic [29:0] raw_total;
  logic [29:0] blk_num;
  logic [31:0] idat_size;

  logic [2:0]  eph;
  logic [2:0]  raw_entry;
  logic [2:0]  ph_next;
  logic [13:0] eff_w;
  logic [13:0] eff_h;
  logic [15:0] row_len;
  logic [29:0] raw_prod;
  logic [15:0] blk_len;
  logic        bh_final;
  logic [29:0] raw_dec;
  logic [15:0] blk_dec;
  logic        slot_free;
  logic        suppress;
  logic        gen;
  logic        is_data;
  logic        natural_last;
  logic        trl_end;
  logic [7:0]  cur_byte;
  logic [31:0] ihdr_fin;
  logic [31:0] crc_fin;
  logic [29:0] div_num;
  logic [60:0] div_prod;
  logic [16:0] s1;
  logic [15:0] lo_n;
  logic [16:0] s2;
  logic [15:0] hi_n;
  logic [15:0] col_inc;

  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  // Effective image size and raw data length
  assign eff_w    = (image_width == 14'd0) ? 14'd1 : image_width;
  assign eff_h    = (image_height == 14'd0) ? 14'd1 : image_height;
  assign row_len  = {2'b00, eff_w} + {1'b0, eff_w, 1'b0};
  assign raw_prod = {14'd0, row_len + 16'd1} * {16'd0, eff_h};

  // Block framing
  assign bh_final = (raw_left <= LIMIT30);
  assign blk_len  = bh_final ? raw_left[15:0] : LIMIT16;
  assign raw_dec  = raw_left - 30'd1;
  assign blk_dec  = blk - 16'd1;

  // Resolve the phase a new step opens with
  assign raw_entry = (col == 16'd0) ? ((blk == 16'd0) ? P_FBH : P_FB)
                                    : ((blk == 16'd0) ? P_PBH : P_PB);
  assign eph = (ph == P_START) ? (started ? raw_entry : P_HDR) : ph;

  assign slot_free = !out_valid || !out_stall;
  assign suppress  = (cnt >= RUN_CAP);
  assign gen       = head.valid && (slot_free || suppress);

  assign trl_end      = (idx == 6'd19);
  assign natural_last = ((eph == P_PB) && (raw_dec != 30'd0)) || ((eph == P_TRL) && trl_end);
  assign pop          = gen && natural_last;

  assign ihdr_fin = ihdr_crc ^ CRC_ONES;
  assign crc_fin  = crc ^ CRC_ONES;

  // Select the byte of the current position
  always_comb begin
    cur_byte = 8'd0;
    is_data  = 1'b0;
    unique case (eph)
      P_HDR: begin
        is_data = (idx >= 6'd37);
        case (idx)
          6'd0:  cur_byte = 8'd137;
          6'd1:  cur_byte = 8'd80;
          6'd2:  cur_byte = 8'd78;
          6'd3:  cur_byte = 8'd71;
          6'd4:  cur_byte = 8'd13;
          6'd5:  cur_byte = 8'd10;
          6'd6:  cur_byte = 8'd26;
          6'd7:  cur_byte = 8'd10;
          6'd11: cur_byte = 8'd13;
          6'd12: cur_byte = 8'h49;
          6'd13: cur_byte = 8'h48;
          6'd14: cur_byte = 8'h44;
          6'd15: cur_byte = 8'h52;
          6'd18: cur_byte = {2'b00, eff_w[13:8]};
          6'd19: cur_byte = eff_w[7:0];
          6'd22: cur_byte = {2'b00, eff_h[13:8]};
          6'd23: cur_byte = eff_h[7:0];
          6'd24: cur_byte = 8'd8;
          6'd25: cur_byte = 8'd2;
          6'd29, 6'd30, 6'd31, 6'd32: cur_byte = be_byte(ihdr_fin, 2'(idx - 6'd29));
          6'd33, 6'd34, 6'd35, 6'd36: cur_byte = be_byte(idat_size, 2'(idx - 6'd33));
          6'd37: cur_byte = 8'h49;
          6'd38: cur_byte = 8'h44;
          6'd39: cur_byte = 8'h41;
          6'd40: cur_byte = 8'h54;
          6'd41: cur_byte = 8'h78;
          6'd42: cur_byte = 8'h01;
          default: cur_byte = 8'd0;
        endcase
      end
      P_FBH, P_PBH: begin
        is_data = 1'b1;
        case (idx)
          6'd0:    cur_byte = {7'd0, bh_final};
          6'd1:    cur_byte = blk_len[7:0];
          6'd2:    cur_byte = blk_len[15:8];
          6'd3:    cur_byte = ~blk_len[7:0];
          default: cur_byte = ~blk_len[15:8];
        endcase
      end
      P_FB: begin
        is_data  = 1'b1;
        cur_byte = 8'd0;
      end
      P_PB: begin
        is_data  = 1'b1;
        cur_byte = head.data;
      end
      P_TRL: begin
        is_data = (idx < 6'd4);
        if (idx < 6'd4) begin
          cur_byte = be_byte({adl_hi, adl_lo}, idx[1:0]);
        end else if (idx < 6'd8) begin
          cur_byte = be_byte(crc_fin, idx[1:0]);
        end else if (idx < 6'd12) begin
          cur_byte = 8'd0;
        end else if (idx == 6'd12) begin
          cur_byte = 8'h49;
        end else if (idx == 6'd13) begin
          cur_byte = 8'h45;
        end else if (idx == 6'd14) begin
          cur_byte = 8'h4E;
        end else if (idx == 6'd15) begin
          cur_byte = 8'h44;
        end else begin
          cur_byte = be_byte(IEND_CRC, idx[1:0]);
        end
      end
      default: cur_byte = 8'd0;
    endcase
  end

  // Next phase after the current byte
  always_comb begin
    ph_next = eph;
    unique case (eph)
      P_HDR:   ph_next = (idx == 6'd42) ? P_FBH : P_HDR;
      P_FBH:   ph_next = (idx == 6'd4) ? P_FB : P_FBH;
      P_PBH:   ph_next = (idx == 6'd4) ? P_PB : P_PBH;
      P_FB:    ph_next = (raw_dec == 30'd0) ? P_TRL : ((blk_dec == 16'd0) ? P_PBH : P_PB);
      P_PB:    ph_next = (raw_dec == 30'd0) ? P_TRL : P_START;
      P_TRL:   ph_next = trl_end ? P_START : P_TRL;
      default: ph_next = P_START;
    endcase
  end

  // Block count by reciprocal, Adler sums and column count
  assign div_num  = raw_total + (LIMIT30 - 30'd1);
  assign div_prod = 61'(div_num) * 61'(BLK_RECIP);
  assign s1      = {1'b0, adl_lo} + {9'd0, cur_byte};
  assign lo_n    = (s1 >= ADLER_MOD) ? 16'(s1 - ADLER_MOD) : s1[15:0];
  assign s2      = {1'b0, adl_hi} + {1'b0, lo_n};
  assign hi_n    = (s2 >= ADLER_MOD) ? 16'(s2 - ADLER_MOD) : s2[15:0];
  assign col_inc = col + 16'd1;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= P_START;
      idx     <= 6'd0;
      cnt     <= 6'd0;
      started <= 1'b0;
    end else if (gen) begin
      ph  <= ph_next;
      idx <= (ph_next != eph) ? 6'd0 : idx + 6'd1;
      if (pop) begin
        cnt <= 6'd0;
      end else if (!suppress) begin
        cnt <= cnt + 6'd1;
      end
      if (eph == P_HDR && idx == 6'd42) begin
        started <= 1'b1;
      end else if (eph == P_TRL && trl_end) begin
        started <= 1'b0;
      end
    end
  end

  // Checksums and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_ONES;
      adl_lo   <= 16'd1;
      adl_hi   <= 16'd0;
      col      <= 16'd0;
      blk      <= 16'd0;
      raw_left <= 30'd0;
    end else if (gen) begin
      if (is_data) begin
        crc <= crc32_step(crc, cur_byte);
      end else if ((eph == P_HDR && idx == 6'd33) || (eph == P_TRL && trl_end)) begin
        crc <= CRC_ONES;
      end
      if (eph == P_HDR && idx == 6'd42) begin
        adl_lo   <= 16'd1;
        adl_hi   <= 16'd0;
        col      <= 16'd0;
        blk      <= 16'd0;
        raw_left <= raw_total;
      end
      if ((eph == P_FBH || eph == P_PBH) && idx == 6'd4) begin
        blk <= blk_len;
      end
      if (eph == P_FB || eph == P_PB) begin
        adl_lo   <= lo_n;
        adl_hi   <= hi_n;
        blk      <= blk_dec;
        raw_left <= raw_dec;
      end
      if (eph == P_PB) begin
        col <= (col_inc >= row_len) ? 16'd0 : col_inc;
      end
    end
  end

  // Image header CRC, block count and IDAT length
  always_ff @(posedge clk) begin
    if (gen && eph == P_HDR) begin
      if (idx == 6'd0) begin
        ihdr_crc  <= CRC_ONES;
        raw_total <= raw_prod;
      end
      if (idx >= 6'd12 && idx <= 6'd28) begin
        ihdr_crc <= crc32_step(ihdr_crc, cur_byte);
      end
      if (idx == 6'd1) begin
        blk_num <= 30'(div_prod >> DIV_SHIFT);
      end
      if (idx == 6'd32) begin
        idat_size <= {2'b00, raw_total} + {blk_num, 2'b00} + {2'b00, blk_num} + 32'd6;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen && !suppress) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen && !suppress) begin
      out_byte    <= cur_byte;
      last_of_run <= natural_last || (cnt == RUN_CAP - 6'd1);
      end_of_file <= (eph == P_TRL) && trl_end;
    end
  end

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_file) |-> last_of_run)
    else $error("end of file without end of run");

  a_blk_raw: assert property (@(posedge clk) disable iff (rst)
    started |-> ({14'd0, blk} <= raw_left))
    else $error("block count exceeds remaining raw data");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_hdr_idx: assert property (@(posedge clk) disable iff (rst)
    (ph == P_HDR) |-> (idx <= 6'd42))
    else $error("header index out of range");

  a_stop_trl: assert property (@(posedge clk) disable iff (rst)
    $fell(started) |-> $past(gen && eph == P_TRL))
    else $error("stream closed outside trailer");

endmodule
`default_nettype wire

// ===== rtl/core/png_stored_deflate_encoder_unit.sv =====
// A colour byte enters a two-word queue, and its first output word is registered
// from the queue slot. Output runs at one word per cycle while out_stall is low.
// A plain colour byte yields one word; the first byte of a file adds 43 header words,
// a row start 1, a block start 5, the last byte 20 trailer words, set by the sequencer.
// Reset clears all control state; image_width and image_height return to 1.
`default_nettype none
module png_stored_deflate_encoder_unit
  import pse_pkg::*;
#(
  parameter int BLOCK_LIMIT = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  pixel_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_file
);

  logic [13:0] image_width;
  logic [13:0] image_height;
  head_t       head;
  logic        pop;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 14'd1;
      image_height <= 14'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    image_width  <= image_width;
      endcase
    end
  end

  pse_in_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_byte (pixel_byte),
    .pop        (pop),
    .head       (head)
  );

  pse_seq #(
    .BLOCK_LIMIT (BLOCK_LIMIT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_file  (end_of_file)
  );

endmodule
`default_nettype wire

// ===== tb/sv/png_stored_deflate_encoder_unit_tb.sv =====
// Self-checking testbench for the PNG stored-deflate encoder: predicted byte stream vs DUT.
`timescale 1ns / 1ps
module png_stored_deflate_encoder_unit_tb;
  import pse_pkg::*;

  localparam int BLOCK_BYTES = 65535;
  localparam int MAX_RUN = 50;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } png_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_WIDTH;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_file;

  png_stored_deflate_encoder_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .pixel_byte(pixel_byte), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last_of_run(last_of_run), .end_of_file(end_of_file)
  );

  always #6 clk = ~clk;

  // Predicted encoder state
  logic [13:0] width_reg, height_reg;
  logic [31:0] idat_crc, adler_a, adler_b, col_bytes, rows_done, blk_left, raw_left;
  logic        in_file;
  png_word_t   run_q[$];
  png_word_t   png_stream_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) x = x[0] ? (32'hEDB88320 ^ (x >> 1)) : (x >> 1);
    return x;
  endfunction

  function automatic logic [31:0] eff_width();
    return (width_reg == 0) ? 32'd1 : {18'd0, width_reg};
  endfunction

  function automatic logic [31:0] eff_height();
    return (height_reg == 0) ? 32'd1 : {18'd0, height_reg};
  endfunction

  task automatic emit_word(logic [7:0] b);
    if (run_q.size() < MAX_RUN) run_q.push_back({b, 1'b0, 1'b0});
  endtask

  task automatic emit_idat(logic [7:0] b);
    idat_crc = crc32_byte(idat_crc, b);
    emit_word(b);
  endtask

  task automatic emit_be32(logic [31:0] v, bit in_idat);
    for (int s = 24; s >= 0; s -= 8) begin
      if (in_idat) emit_idat(v[s +: 8]);
      else emit_word(v[s +: 8]);
    end
  endtask

  // Raw deflate byte; open a stored block when the previous one is used up
  task automatic emit_raw(logic [7:0] b);
    logic [31:0] len;
    if (blk_left == 0) begin
      len = (raw_left > BLOCK_BYTES) ? BLOCK_BYTES : raw_left;
      emit_idat((len == raw_left) ? 8'd1 : 8'd0);
      emit_idat(len[7:0]);
      emit_idat(len[15:8]);
      emit_idat(~len[7:0]);
      emit_idat(~len[15:8]);
      blk_left = len;
    end
    emit_idat(b);
    adler_a = (adler_a + b) % 65521;
    adler_b = (adler_b + adler_a) % 65521;
    blk_left--;
    raw_left--;
  endtask

  task automatic start_file();
    logic [31:0] w, h, c;
    logic [63:0] raw, nblk, idat_size;
    logic [7:0]  hdr[13];
    logic [7:0]  sig[8];
    logic [31:0] ihdr_tag, idat_tag;
    sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
    ihdr_tag = "IHDR";
    idat_tag = "IDAT";
    w = eff_width();
    h = eff_height();
    raw = (64'(w) * 3 + 1) * 64'(h);
    nblk = (raw + BLOCK_BYTES - 1) / BLOCK_BYTES;
    idat_size = 2 + raw + nblk * 5 + 4;
    c = 32'hFFFFFFFF;
    hdr = '{8'd0, 8'd0, w[15:8], w[7:0], 8'd0, 8'd0, h[15:8], h[7:0],
            8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
    for (int i = 0; i < 8; i++) emit_word(sig[i]);
    emit_be32(32'd13, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      emit_word(ihdr_tag[i*8 +: 8]);
      c = crc32_byte(c, ihdr_tag[i*8 +: 8]);
    end
    for (int i = 0; i < 13; i++) begin
      emit_word(hdr[i]);
      c = crc32_byte(c, hdr[i]);
    end
    emit_be32(~c, 1'b0);
    emit_be32(idat_size[31:0], 1'b0);
    idat_crc = 32'hFFFFFFFF;
    for (int i = 3; i >= 0; i--) emit_idat(idat_tag[i*8 +: 8]);
    emit_idat(8'h78);
    emit_idat(8'h01);
    adler_a = 1;
    adler_b = 0;
    col_bytes = 0;
    rows_done = 0;
    blk_left = 0;
    raw_left = raw[31:0];
    in_file = 1'b1;
  endtask

  task automatic finish_file();
    logic [31:0] c, iend_tag;
    iend_tag = "IEND";
    c = 32'hFFFFFFFF;
    emit_be32({adler_b[15:0], adler_a[15:0]}, 1'b1);
    emit_be32(~idat_crc, 1'b0);
    emit_be32(32'd0, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      emit_word(iend_tag[i*8 +: 8]);
      c = crc32_byte(c, iend_tag[i*8 +: 8]);
    end
    emit_be32(~c, 1'b0);
    if (run_q.size() > 0) run_q[run_q.size()-1].eof = 1'b1;
    idat_crc = 32'hFFFFFFFF;
    in_file = 1'b0;
  endtask

  // Work out the words one colour byte causes and queue them
  task automatic predict_png_words(logic [7:0] px);
    run_q.delete();
    if (!in_file) start_file();
    if (raw_left > 0 && col_bytes == 0) emit_raw(8'd0);
    if (raw_left > 0) begin
      emit_raw(px);
      col_bytes = (col_bytes + 1) & 32'hFFFF;
      if (col_bytes >= eff_width() * 3) begin
        col_bytes = 0;
        rows_done = (rows_done + 1) & 32'h3FFF;
      end
    end
    if (raw_left == 0) finish_file();
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) png_stream_q.push_back(run_q[i]);
  endtask

  // Offer one colour byte and hold it until taken
  task automatic send_pixel(logic [7:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_png_words(b);
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register once the encoder has drained
  task automatic write_reg(logic idx, logic [13:0] value);
    hold_input();
    while (png_stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic send_image(logic [13:0] w, logic [13:0] h, int fill);
    int n;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    n = 3 * eff_width() * eff_height();
    for (int i = 0; i < n; i++) begin
      case (fill)
        0: send_pixel(8'h00);
        1: send_pixel(8'hFF);
        2: send_pixel(i[0] ? 8'h55 : 8'hAA);
        default: send_pixel(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic test_directed();
    // Reset values, then zero registers treated as one, then 00/FF and 55/AA fills
    send_pixel(8'h80);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_image(14'd0, 14'd0, 1);
    send_image(14'd1, 14'd1, 0);
    send_image(14'd2, 14'd1, 2);
  endtask

  task automatic test_random_images(int budget);
    int sent;
    logic [13:0] w, h;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? 14'd0 : 14'($urandom_range(4, 1));
      h = ($urandom_range(9) == 0) ? 14'd0 : 14'($urandom_range(3, 1));
      send_image(w, h, 3);
      sent += 3 * eff_width() * eff_height();
    end
  endtask

  task automatic test_tall_image();
    // Many one-pixel rows: a filter byte on every third colour byte
    send_image(14'd1, 14'd12, 3);
  endtask

  // Drive the result stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // Compare each delivered word with the oldest prediction
  always @(posedge clk) begin
    png_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (png_stream_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h last %b eof %b",
                                      out_byte, last_of_run, end_of_file);
      end else begin
        want = png_stream_q.pop_front();
        if (want.data !== out_byte || want.last !== last_of_run || want.eof !== end_of_file) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h/%b/%b got %h/%b/%b", want.data, want.last,
                     want.eof, out_byte, last_of_run, end_of_file);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("png_stored_deflate_encoder_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    width_reg = 14'd1;
    height_reg = 14'd1;
    idat_crc = 32'hFFFFFFFF;
    adler_a = 1;
    adler_b = 0;
    col_bytes = 0;
    rows_done = 0;
    blk_left = 0;
    raw_left = 0;
    in_file = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 6;
    recv_idle = 61;
    test_directed();
    test_random_images(100);
    send_idle = 61;
    recv_idle = 6;
    test_random_images(100);
    send_idle = 0;
    recv_idle = 0;
    test_random_images(100);
    test_tall_image();
    hold_input();
    while (png_stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && png_stream_q.size() == 0) begin
      $display("png_stored_deflate_encoder_unit_tb OK");
    end else begin
      $display("png_stored_deflate_encoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pse_pkg.sv
rtl/core/pse_in_queue.sv
rtl/core/pse_seq.sv
rtl/core/png_stored_deflate_encoder_unit.sv
tb/sv/png_stored_deflate_encoder_unit_tb.sv
